@@ rtl/sst_pkg.sv @@
// Shared types and constants of the sorted set table: request and result beats,
// request kinds, status codes and the control bundle that drives the cell chain.
// No dependencies.
`default_nettype none

package sst_pkg;

    // Field widths of the request and result beats
    localparam int KEY_W   = 32;
    localparam int POS_W   = 6;
    localparam int CNT_W   = 7;
    localparam int KIND_W  = 3;
    localparam int STAT_W  = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT     = 3'd0,
        KIND_DELETE_KEY = 3'd1,
        KIND_DELETE_POS = 3'd2,
        KIND_FIND_KEY   = 3'd3,
        KIND_READ_POS   = 3'd4,
        KIND_NEXT       = 3'd5,
        KIND_RESET_CUR  = 3'd6
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef struct packed {
        kind_t                     kind;
        logic signed [KEY_W-1:0]   key;
        logic        [POS_W-1:0]   position;
    } request_t;

    typedef struct packed {
        status_t                   status;
        logic        [POS_W-1:0]   found_position;
        logic signed [KEY_W-1:0]   found_key;
        logic        [CNT_W-1:0]   entry_count;
    } result_t;

    // Broadcast to every cell in the chain
    typedef struct packed {
        logic                      ins;         // open a slot at the insert point
        logic                      del;         // close the slot of the removed entry
        logic                      del_by_pos;  // removed slot given by pos, not by key
        logic        [POS_W-1:0]   pos;         // position for delete by position
        logic        [POS_W-1:0]   rd_idx;      // cell that drives the read bus
        logic signed [KEY_W-1:0]   key;         // request key
        logic        [CNT_W-1:0]   count;       // entries held before this beat
    } cell_ctrl_t;

    // Compare flags each cell reports back
    typedef struct packed {
        logic lt;   // valid and stored key below request key
        logic eq;   // valid and stored key equal to request key
        logic bnd;  // first cell that is not below the request key
    } cell_flag_t;

endpackage

`default_nettype wire

@@ rtl/sorted_set_table_top.sv @@
// Top level of the sorted set table: the chain of key cells, entry count, cursor
// and the registered result beat. Depends on sst_pkg and sst_cell.
`default_nettype none

// A request beat is taken at every clock edge with start high; busy stays low,
// so one request is taken per cycle. Its result is registered: it appears on
// result with done high in the cycle after, is shown for a single cycle, and
// the receiver cannot stall it. Each request is decided combinationally: every
// cell compares its key against the request in parallel, and insert or delete
// shifts the row of cells by one slot at the edge that registers the result.
// Keys stay in ascending signed order; entry_count reports the keys held after
// the request. Reads of the key at a position or through the cursor go through
// an OR bus fed by all cells. CAPACITY may range from 2 to 64.
module sorted_set_table_top #(
    parameter int CAPACITY = 64
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      start,
    input  wire sst_pkg::request_t   request,
    output logic                     busy,
    output logic                     done,
    output sst_pkg::result_t         result
);

    localparam int KW = sst_pkg::KEY_W;
    localparam int PW = sst_pkg::POS_W;
    localparam int CW = sst_pkg::CNT_W;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    sst_pkg::cell_ctrl_t          ctrl;
    sst_pkg::cell_flag_t          flags   [CAPACITY];
    logic signed [KW-1:0]         cell_key[CAPACITY];
    logic        [KW-1:0]         cell_rd [CAPACITY];
    logic        [CAPACITY-1:0]   lt_vec;

    logic        [CW-1:0]         count_reg, count_next;
    logic        [PW-1:0]         cur_reg, cur_next;
    logic                         done_reg, done_next;
    sst_pkg::result_t             res_reg, res_next;

    logic                         any_eq;
    logic        [PW-1:0]         eq_pos;
    logic        [PW-1:0]         ins_pos;
    logic        [KW-1:0]         rd_key;

    // Cursor after removing the entry at p, given the new count
    function automatic logic [PW-1:0] cur_after_remove(
        input logic [PW-1:0] cur,
        input logic [PW-1:0] p,
        input logic [CW-1:0] new_count
    );
        logic [PW-1:0] c;
        begin
            c = cur;
            if (p < cur)
            begin
                c = cur - 1'b1;
            end
            else if (p == cur)
            begin
                c = '0;
            end
            if ({1'b0, c} >= new_count)
            begin
                c = '0;
            end
            return c;
        end
    endfunction

    // Build the chain of cells
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic                  left_lt;
            logic signed [KW-1:0]  left_key;
            logic signed [KW-1:0]  right_key;

            if (gi == 0)
            begin : g_first
                assign left_lt  = 1'b1;
                assign left_key = request.key;
            end
            else
            begin : g_mid
                assign left_lt  = lt_vec[gi-1];
                assign left_key = cell_key[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_key = '0;
            end
            else
            begin : g_inner
                assign right_key = cell_key[gi+1];
            end

            sst_cell #(
                .IDX (gi)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .left_lt   (left_lt),
                .left_key  (left_key),
                .right_key (right_key),
                .flags     (flags[gi]),
                .key_q     (cell_key[gi]),
                .rd_key    (cell_rd[gi])
            );

            assign lt_vec[gi] = flags[gi].lt;
        end
    endgenerate

    // Collect the flags of all cells into positions and the read key
    always_comb
    begin
        any_eq  = 1'b0;
        eq_pos  = '0;
        ins_pos = '0;
        rd_key  = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            any_eq  = any_eq | flags[i].eq;
            eq_pos  = eq_pos  | (flags[i].eq  ? PW'(i) : '0);
            ins_pos = ins_pos | (flags[i].bnd ? PW'(i) : '0);
            rd_key  = rd_key  | cell_rd[i];
        end
    end

    // Decode the request, steer the cells and form the result
    always_comb
    begin
        logic [PW-1:0] c;
        logic [CW-1:0] c_inc;

        c     = ({1'b0, cur_reg} >= count_reg) ? '0 : cur_reg;
        c_inc = {1'b0, c} + 1'b1;

        ctrl            = '0;
        ctrl.pos        = request.position;
        ctrl.key        = request.key;
        ctrl.count      = count_reg;
        ctrl.rd_idx     = (request.kind == sst_pkg::KIND_NEXT) ? c : request.position;

        count_next      = count_reg;
        cur_next        = cur_reg;
        done_next       = start;
        res_next        = res_reg;

        if (start)
        begin
            res_next.status         = sst_pkg::ST_OK;
            res_next.found_position = '0;
            res_next.found_key      = '0;

            case (request.kind)
                sst_pkg::KIND_INSERT:
                begin
                    if (any_eq)
                    begin
                        res_next.status         = sst_pkg::ST_DUPLICATE;
                        res_next.found_position = eq_pos;
                    end
                    else if (count_reg >= CAP_CNT)
                    begin
                        res_next.status = sst_pkg::ST_FULL;
                    end
                    else
                    begin
                        ctrl.ins                = 1'b1;
                        count_next              = count_reg + 1'b1;
                        res_next.found_position = ins_pos;
                        if ((cur_reg != '0) && (ins_pos <= cur_reg))
                        begin
                            cur_next = cur_reg + 1'b1;
                        end
                    end
                end
                sst_pkg::KIND_DELETE_KEY:
                begin
                    if (count_reg == '0)
                    begin
                        res_next.status = sst_pkg::ST_EMPTY;
                    end
                    else if (any_eq)
                    begin
                        ctrl.del                = 1'b1;
                        count_next              = count_reg - 1'b1;
                        cur_next                = cur_after_remove(cur_reg, eq_pos,
                                                                   count_reg - 1'b1);
                        res_next.found_position = eq_pos;
                    end
                    else
                    begin
                        res_next.status = sst_pkg::ST_NOT_FOUND;
                    end
                end
                sst_pkg::KIND_DELETE_POS:
                begin
                    if (count_reg == '0)
                    begin
                        res_next.status = sst_pkg::ST_EMPTY;
                    end
                    else if ({1'b0, request.position} >= count_reg)
                    begin
                        res_next.status = sst_pkg::ST_NOT_FOUND;
                    end
                    else
                    begin
                        ctrl.del                = 1'b1;
                        ctrl.del_by_pos         = 1'b1;
                        count_next              = count_reg - 1'b1;
                        cur_next                = cur_after_remove(cur_reg, request.position,
                                                                   count_reg - 1'b1);
                        res_next.found_position = request.position;
                    end
                end
                sst_pkg::KIND_FIND_KEY:
                begin
                    if (any_eq)
                    begin
                        res_next.found_position = eq_pos;
                    end
                    else
                    begin
                        res_next.status = sst_pkg::ST_NOT_FOUND;
                    end
                end
                sst_pkg::KIND_READ_POS:
                begin
                    if ({1'b0, request.position} < count_reg)
                    begin
                        res_next.found_position = request.position;
                        res_next.found_key      = rd_key;
                    end
                    else
                    begin
                        res_next.status = sst_pkg::ST_NOT_FOUND;
                    end
                end
                sst_pkg::KIND_NEXT:
                begin
                    if (count_reg == '0)
                    begin
                        res_next.status = sst_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        res_next.found_position = c;
                        res_next.found_key      = rd_key;
                        cur_next = (c_inc >= count_reg) ? '0 : c_inc[PW-1:0];
                    end
                end
                sst_pkg::KIND_RESET_CUR:
                begin
                    cur_next = '0;
                end
                default:
                begin
                    // unused kind: no change, plain ok result
                end
            endcase

            res_next.entry_count = count_next;
        end
    end

    // Hold control state and the result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            cur_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            cur_reg   <= cur_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = res_reg;

    // Checks on count, cursor and result timing
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("entry count above capacity");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) || ({1'b0, cur_reg} < count_reg))
        else $error("cursor outside held entries");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("result beat missing after request");

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.entry_count == count_reg))
        else $error("reported count differs from held count");

    a_full_only_at_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == sst_pkg::ST_FULL)) |-> (count_reg == CAP_CNT))
        else $error("full reported below capacity");

endmodule

`default_nettype wire

@@ rtl/sst_cell.sv @@
// One slot of the sorted chain: holds a key, compares it with the request key
// and shifts to or from its neighbors on insert and delete. Depends on sst_pkg.
`default_nettype none

module sst_cell #(
    parameter int IDX = 0
) (
    input  wire                                    clk,
    input  wire sst_pkg::cell_ctrl_t               ctrl,
    input  wire                                    left_lt,
    input  wire logic signed [sst_pkg::KEY_W-1:0]  left_key,
    input  wire logic signed [sst_pkg::KEY_W-1:0]  right_key,
    output sst_pkg::cell_flag_t                    flags,
    output logic signed [sst_pkg::KEY_W-1:0]       key_q,
    output logic        [sst_pkg::KEY_W-1:0]       rd_key
);

    localparam logic [sst_pkg::POS_W-1:0] MY_IDX = sst_pkg::POS_W'(IDX);

    logic signed [sst_pkg::KEY_W-1:0] key_reg;
    logic signed [sst_pkg::KEY_W-1:0] key_next;
    logic                             valid;
    logic                             shift_down;

    // Compare against the request key
    assign valid     = ({1'b0, MY_IDX} < ctrl.count);
    assign flags.lt  = valid && ($signed(key_reg) < $signed(ctrl.key));
    assign flags.eq  = valid && ($signed(key_reg) == $signed(ctrl.key));
    assign flags.bnd = left_lt && !flags.lt;

    // Drive the read bus when addressed
    assign rd_key = (MY_IDX == ctrl.rd_idx) ? key_reg : '0;
    assign key_q  = key_reg;

    // Pick the next key: hold, take the request, or shift from a neighbor
    assign shift_down = ctrl.del_by_pos ? (MY_IDX >= ctrl.pos) : !flags.lt;

    always_comb
    begin
        key_next = key_reg;
        if (ctrl.ins && !flags.lt)
        begin
            key_next = left_lt ? ctrl.key : left_key;
        end
        else if (ctrl.del && shift_down)
        begin
            key_next = right_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

`default_nettype wire
